// ===== design/bounded_list_table_engine_unit_defines.svh =====
// Assertion macros shared by the list engine RTL.
`ifndef BOUNDED_LIST_TABLE_ENGINE_UNIT_DEFINES_SVH
`define BOUNDED_LIST_TABLE_ENGINE_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BLTE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition in one cycle leads to a consequence in the next.
`define BLTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/blte_pkg.sv =====
// Types and constants for the bounded list engine.
package blte_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int CNT_W      = 6;
    localparam int IDX_W      = 5;
    localparam int VALUE_W    = 32;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    localparam logic [CNT_W-1:0] CAP_RESET = 6'd32;
    localparam logic [CNT_W-1:0] DEPTH_CNT = 6'd32;

    // Register map: word index carried in paddr[2].
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_DELETE = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_FIND   = 3'd4;
    localparam logic [2:0] CMD_SORT   = 3'd5;
    localparam logic [2:0] CMD_SEARCH = 3'd6;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_OOR  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_SEARCH
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_SORT
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] cnt;
        logic             odd;
    } cell_ctrl_t;

    typedef struct packed {
        logic [2:0]                cmd;
        logic [CNT_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } req_item_t;

    typedef struct packed {
        logic [1:0]                status;
        logic                      found;
        logic [IDX_W-1:0]          found_index;
        logic signed [VALUE_W-1:0] read_value;
        logic [CNT_W-1:0]          count;
    } rsp_item_t;

endpackage

// ===== design/bounded_list_table_engine_unit.sv =====
// Bounded list engine: a row of slot cells under a small command sequencer.
//
// Commands arrive on the req channel (valid/ready) as one beat each and
// every command returns exactly one beat on the rsp channel. The capacity
// register sits at APB byte address 0; write it only while the block is idle.
//
// For append, insert, delete, read, find and unknown commands the result
// register loads at the accepting edge and the next command can be taken
// in the following cycle, so with rsp_ready high they stream at one
// command per cycle. Sort runs odd-even transposition over the slot row,
// one phase per cycle. Binary search probes one slot per cycle through the
// single read mux. The next command is accepted once the sequencer is back
// in idle.
//
// Reset clears the entry count and loads capacity 32; slot contents are
// undefined until written. When the receiver stalls, the result beat holds
// in the output register, and one more command is accepted only in the
// cycle the waiting beat is taken.
`include "bounded_list_table_engine_unit_defines.svh"

module bounded_list_table_engine_unit
    import blte_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_item_t         req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_item_t         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    state_t                       state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             phase_reg, phase_next;
    logic signed [CNT_W:0]        lo_reg, lo_next;
    logic signed [CNT_W:0]        hi_reg, hi_next;
    logic signed [DATA_WIDTH-1:0] key_reg, key_next;
    logic [CNT_W-1:0]             capacity_reg;
    logic                         rsp_valid_reg;
    rsp_item_t                    rsp_reg, rsp_next;
    logic                         rsp_load;

    logic                         req_fire;
    logic [CNT_W-1:0]             cap_eff;
    logic signed [DATA_WIDTH-1:0] req_key;
    cell_ctrl_t                   ctrl;
    logic signed [DATA_WIDTH-1:0] cell_data [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]        match_vec;
    logic [LIST_DEPTH-1:0]        first_hit;
    logic [IDX_W-1:0]             find_idx;
    logic [CNT_W-1:0]             mid_sum;
    logic [IDX_W-1:0]             mid;
    logic [IDX_W-1:0]             probe_idx;
    logic signed [DATA_WIDTH-1:0] probe_data;
    logic signed [VALUE_W-1:0]    probe_rd;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(capacity_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAP_RESET;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY))
            capacity_reg <= pwdata[CNT_W-1:0];
    end

    assign cap_eff = (capacity_reg > DEPTH_CNT) ? DEPTH_CNT : capacity_reg;

    // Narrow or widen the incoming value to the stored width.
    generate
        if (DATA_WIDTH <= VALUE_W)
        begin : g_key_narrow
            assign req_key = req.value[DATA_WIDTH-1:0];
        end
        else
        begin : g_key_wide
            assign req_key = {{(DATA_WIDTH-VALUE_W){req.value[VALUE_W-1]}}, req.value};
        end
    endgenerate

    // Slot row
    generate
        for (genvar i = 0; i < LIST_DEPTH; i++)
        begin : g_cell
            logic signed [DATA_WIDTH-1:0] left_d;
            logic signed [DATA_WIDTH-1:0] right_d;

            if (i == 0)
            begin : g_first
                assign left_d = cell_data[i];
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[i-1];
            end

            if (i == LIST_DEPTH - 1)
            begin : g_last
                assign right_d = cell_data[i];
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[i+1];
            end

            blte_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .IDX        (i)
            ) u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .key   (req_key),
                .left  (left_d),
                .right (right_d),
                .data  (cell_data[i]),
                .match (match_vec[i])
            );
        end
    endgenerate

    // First matching slot: isolate the lowest set bit, then encode it.
    assign first_hit = match_vec & (~match_vec + LIST_DEPTH'(1));

    always_comb
    begin
        find_idx = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (first_hit[i])
                find_idx = find_idx | IDX_W'(i);
        end
    end

    // Single probe port shared by read and binary search.
    assign mid_sum    = lo_reg[CNT_W-1:0] + hi_reg[CNT_W-1:0];
    assign mid        = mid_sum[CNT_W-1:1];
    assign probe_idx  = (state_reg == ST_SEARCH) ? mid : req.position[IDX_W-1:0];
    assign probe_data = cell_data[probe_idx];

    generate
        if (DATA_WIDTH >= VALUE_W)
        begin : g_rd_narrow
            assign probe_rd = probe_data[VALUE_W-1:0];
        end
        else
        begin : g_rd_wide
            assign probe_rd = {{(VALUE_W-DATA_WIDTH){probe_data[DATA_WIDTH-1]}}, probe_data};
        end
    endgenerate

    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign req_fire  = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        key_next   = key_reg;
        rsp_load   = 1'b0;
        rsp_next   = '0;
        ctrl.op    = CELL_HOLD;
        ctrl.pos   = req.position;
        ctrl.cnt   = count_reg;
        ctrl.odd   = phase_reg[0];

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    rsp_load = 1'b1;
                    case (req.cmd)
                        CMD_APPEND:
                        begin
                            if (count_reg >= cap_eff)
                                rsp_next.status = STAT_FULL;
                            else
                            begin
                                ctrl.op    = CELL_INSERT;
                                ctrl.pos   = count_reg;
                                count_next = count_reg + 6'd1;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (req.position > count_reg)
                                rsp_next.status = STAT_OOR;
                            else if (count_reg >= cap_eff)
                                rsp_next.status = STAT_FULL;
                            else
                            begin
                                ctrl.op    = CELL_INSERT;
                                count_next = count_reg + 6'd1;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (req.position >= count_reg)
                                rsp_next.status = STAT_OOR;
                            else
                            begin
                                ctrl.op    = CELL_DELETE;
                                count_next = count_reg - 6'd1;
                            end
                        end
                        CMD_READ:
                        begin
                            if (req.position >= count_reg)
                                rsp_next.status = STAT_OOR;
                            else
                                rsp_next.read_value = probe_rd;
                        end
                        CMD_FIND:
                        begin
                            rsp_next.found       = |match_vec;
                            rsp_next.found_index = find_idx;
                        end
                        CMD_SORT:
                        begin
                            rsp_load   = 1'b0;
                            phase_next = '0;
                            state_next = ST_SORT;
                        end
                        CMD_SEARCH:
                        begin
                            rsp_load   = 1'b0;
                            lo_next    = '0;
                            hi_next    = $signed({1'b0, count_reg}) - 7'sd1;
                            key_next   = req_key;
                            state_next = ST_SEARCH;
                        end
                        default:
                        begin
                            rsp_next.status = STAT_OK;
                        end
                    endcase
                end
            end
            ST_SORT:
            begin
                // count phases of odd-even transposition leave the row sorted
                if (phase_reg >= count_reg)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctrl.op    = CELL_SORT;
                    phase_next = phase_reg + 6'd1;
                end
            end
            ST_SEARCH:
            begin
                if (lo_reg > hi_reg)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (probe_data == key_reg)
                begin
                    rsp_load             = 1'b1;
                    rsp_next.found       = 1'b1;
                    rsp_next.found_index = mid;
                    state_next           = ST_IDLE;
                end
                else if (probe_data > key_reg)
                    hi_next = $signed({2'b00, mid}) - 7'sd1;
                else
                    lo_next = $signed({2'b00, mid}) + 7'sd1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp_next.count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            phase_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (rsp_load)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `BLTE_ASSERT(a_count_bound, count_reg <= DEPTH_CNT, "entry count beyond list depth")
    `BLTE_ASSERT(a_busy_no_beat, (state_reg != ST_IDLE) |-> !rsp_valid_reg,
                 "result beat pending while sort or search runs")
    `BLTE_ASSERT_NEXT(a_append_grows,
                      req_fire && (req.cmd == CMD_APPEND) && (count_reg < cap_eff),
                      count_reg == $past(count_reg) + 6'd1,
                      "append did not grow the list")
    `BLTE_ASSERT(a_search_window,
                 (state_reg == ST_SEARCH) |-> (hi_reg < $signed({1'b0, count_reg})),
                 "search window beyond entry count")

endmodule

// ===== design/blte_cell.sv =====
// One list slot: holds an entry and trades it with its neighbors.
module blte_cell
    import blte_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int IDX        = 0
)
(
    input  logic                         clk,
    input  cell_ctrl_t                   ctrl,
    input  logic signed [DATA_WIDTH-1:0] key,
    input  logic signed [DATA_WIDTH-1:0] left,
    input  logic signed [DATA_WIDTH-1:0] right,
    output logic signed [DATA_WIDTH-1:0] data,
    output logic                         match
);

    localparam logic [CNT_W-1:0] ME    = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] ME_UP = CNT_W'(IDX + 1);

    logic signed [DATA_WIDTH-1:0] data_reg;
    logic signed [DATA_WIDTH-1:0] data_next;
    logic                         lower;

    // Lower slot of the pair in this phase of the odd-even sort.
    assign lower = (ME[0] == ctrl.odd);

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (ctrl.pos == ME)
                    data_next = key;
                else if (ME > ctrl.pos)
                    data_next = left;
            end
            CELL_DELETE:
            begin
                if (ME >= ctrl.pos)
                    data_next = right;
            end
            CELL_SORT:
            begin
                if (lower)
                begin
                    if ((ME_UP < ctrl.cnt) && (data_reg > right))
                        data_next = right;
                end
                else
                begin
                    if ((ME < ctrl.cnt) && (left > data_reg))
                        data_next = left;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == key) && (ME < ctrl.cnt);

endmodule

// ===== bench/tb_bounded_list_table_engine_unit.sv =====
// Testbench for the bounded list engine: directed table, then random command traffic.
module tb_bounded_list_table_engine_unit
    import blte_pkg::*;
();

    localparam logic [2:0] CMD_UNKNOWN = 3'd7;
    localparam int N_DIRECTED = 25;
    localparam int N_PHASES = 14;
    localparam int PHASE_LEN = 100;

    typedef struct {
        logic             cfg_wr;
        logic [CNT_W-1:0] cfg_cap;
        req_item_t        beat;
        logic             known;
        rsp_item_t        want;
    } plan_row_t;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    req_item_t         req;
    logic              rsp_valid;
    logic              rsp_ready;
    rsp_item_t         rsp;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Shadow copy of the list and its capacity register
    logic signed [VALUE_W-1:0] list_mem [LIST_DEPTH];
    int                        list_len;
    logic [CNT_W-1:0]          cap_reg;

    rsp_item_t pending_results[$];
    int        mismatch_cnt;
    bit        idle_on;
    plan_row_t dir_plan [N_DIRECTED];

    bounded_list_table_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic rsp_item_t apply_list_cmd(input req_item_t c);
        rsp_item_t                 r;
        logic signed [VALUE_W-1:0] key;
        logic signed [VALUE_W-1:0] tmp;
        int                        lim, pos, lo, hi, mid, i, j;
        r = '0;
        key = c.value;
        pos = int'(c.position);
        lim = (int'(cap_reg) > LIST_DEPTH) ? LIST_DEPTH : int'(cap_reg);
        case (c.cmd)
            CMD_APPEND:
            begin
                if (list_len >= lim)
                    r.status = STAT_FULL;
                else
                begin
                    list_mem[list_len] = key;
                    list_len++;
                end
            end
            CMD_INSERT:
            begin
                if (pos > list_len)
                    r.status = STAT_OOR;
                else if (list_len >= lim)
                    r.status = STAT_FULL;
                else
                begin
                    for (i = list_len; i > pos; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos] = key;
                    list_len++;
                end
            end
            CMD_DELETE:
            begin
                if (pos >= list_len)
                    r.status = STAT_OOR;
                else
                begin
                    for (i = pos; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            CMD_READ:
            begin
                if (pos >= list_len)
                    r.status = STAT_OOR;
                else
                    r.read_value = list_mem[pos];
            end
            CMD_FIND:
            begin
                for (i = 0; i < list_len && !r.found; i++)
                begin
                    if (list_mem[i] == key)
                    begin
                        r.found = 1'b1;
                        r.found_index = IDX_W'(i);
                    end
                end
            end
            CMD_SORT:
            begin
                for (i = 0; i + 1 < list_len; i++)
                    for (j = i + 1; j < list_len; j++)
                        if (list_mem[i] > list_mem[j])
                        begin
                            tmp = list_mem[i];
                            list_mem[i] = list_mem[j];
                            list_mem[j] = tmp;
                        end
            end
            CMD_SEARCH:
            begin
                // probe entries as stored, sorted or not
                lo = 0;
                hi = list_len - 1;
                while (lo <= hi && !r.found)
                begin
                    mid = (lo + hi) / 2;
                    if (list_mem[mid] == key)
                    begin
                        r.found = 1'b1;
                        r.found_index = IDX_W'(mid);
                    end
                    else if (list_mem[mid] > key)
                        hi = mid - 1;
                    else
                        lo = mid + 1;
                end
            end
            default:
            begin
            end
        endcase
        r.count = CNT_W'(list_len);
        return r;
    endfunction

    function automatic plan_row_t make_row(input logic cfg_wr, input logic [CNT_W-1:0] cap,
                                           input logic [2:0] op, input logic [CNT_W-1:0] pos,
                                           input logic [VALUE_W-1:0] val, input logic known,
                                           input logic [1:0] st, input logic fnd,
                                           input logic [IDX_W-1:0] fidx,
                                           input logic [VALUE_W-1:0] rv,
                                           input logic [CNT_W-1:0] cnt);
        plan_row_t row;
        row.cfg_wr = cfg_wr;
        row.cfg_cap = cap;
        row.beat.cmd = op;
        row.beat.position = pos;
        row.beat.value = val;
        row.known = known;
        row.want.status = st;
        row.want.found = fnd;
        row.want.found_index = fidx;
        row.want.read_value = rv;
        row.want.count = cnt;
        return row;
    endfunction

    // Drain the list engine, then write capacity through a setup and an access cycle
    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_CAPACITY, 2'b00};
        pwdata <= {{(APB_DW-CNT_W){1'b0}}, cap};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cap_reg = cap;
    endtask

    task automatic issue_cmd(input req_item_t beat, input logic known, input rsp_item_t want);
        rsp_item_t predicted;
        int        n;
        if (idle_on && $urandom_range(0, 99) < 20)
        begin
            req_valid <= 1'b0;
            n = $urandom_range(1, 6);
            repeat (n) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= beat;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = apply_list_cmd(beat);
        pending_results.push_back(known ? want : predicted);
    endtask

    // Receiver side: random stall bursts
    initial
    begin
        int n;
        rsp_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 99) < 15)
            begin
                rsp_ready <= 1'b0;
                n = $urandom_range(1, 6);
                repeat (n) @(posedge clk);
                rsp_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: status %0d count %0d", rsp.status, rsp.count);
                mismatch_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    mismatch_cnt++;
                end
                if (rsp.found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, rsp.found);
                    mismatch_cnt++;
                end
                if (rsp.found_index !== want.found_index)
                begin
                    $error("found_index: expected %0d, actual %0d",
                           want.found_index, rsp.found_index);
                    mismatch_cnt++;
                end
                if (rsp.read_value !== want.read_value)
                begin
                    $error("read_value: expected %0d, actual %0d",
                           want.read_value, rsp.read_value);
                    mismatch_cnt++;
                end
                if (rsp.count !== want.count)
                begin
                    $error("count: expected %0d, actual %0d", want.count, rsp.count);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial
    begin
        req_item_t  beat;
        rsp_item_t  none;
        logic [2:0] op;
        int         k, ph, grow, pick;

        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        none = '0;
        mismatch_cnt = 0;
        idle_on = 1'b1;
        list_len = 0;
        cap_reg = CAP_RESET;

        // Empty list, extremes, full and out-of-range errors, ordering of insert checks
        dir_plan[0]  = make_row(0, 0, CMD_READ,    0,  0,  1, STAT_OOR, 0, 0, 0, 0);
        dir_plan[1]  = make_row(0, 0, CMD_DELETE,  0,  0,  1, STAT_OOR, 0, 0, 0, 0);
        dir_plan[2]  = make_row(0, 0, CMD_FIND,    0,  5,  1, STAT_OK,  0, 0, 0, 0);
        dir_plan[3]  = make_row(0, 0, CMD_SEARCH,  0,  5,  1, STAT_OK,  0, 0, 0, 0);
        dir_plan[4]  = make_row(0, 0, CMD_SORT,    0,  0,  1, STAT_OK,  0, 0, 0, 0);
        dir_plan[5]  = make_row(0, 0, CMD_UNKNOWN, 63, 32'hFFFF_FFFF,
                                1, STAT_OK, 0, 0, 0, 0);
        dir_plan[6]  = make_row(0, 0, CMD_INSERT,  1,  9,  1, STAT_OOR, 0, 0, 0, 0);
        dir_plan[7]  = make_row(0, 0, CMD_APPEND,  0,  32'h7FFF_FFFF,
                                1, STAT_OK, 0, 0, 0, 1);
        dir_plan[8]  = make_row(0, 0, CMD_APPEND,  0,  32'h8000_0000,
                                1, STAT_OK, 0, 0, 0, 2);
        dir_plan[9]  = make_row(0, 0, CMD_INSERT,  0,  32'hFFFF_FFFF,
                                1, STAT_OK, 0, 0, 0, 3);
        dir_plan[10] = make_row(0, 0, CMD_INSERT,  3,  0,  1, STAT_OK,  0, 0, 0, 4);
        dir_plan[11] = make_row(0, 0, CMD_INSERT,  63, 7,  1, STAT_OOR, 0, 0, 0, 4);
        dir_plan[12] = make_row(0, 0, CMD_READ,    0,  0,  1, STAT_OK,  0, 0,
                                32'hFFFF_FFFF, 4);
        dir_plan[13] = make_row(0, 0, CMD_READ,    63, 0,  1, STAT_OOR, 0, 0, 0, 4);
        dir_plan[14] = make_row(0, 0, CMD_FIND,    0,  32'h8000_0000,
                                1, STAT_OK, 1, 2, 0, 4);
        dir_plan[15] = make_row(0, 0, CMD_SEARCH,  0,  0,  0, 0, 0, 0, 0, 0);
        dir_plan[16] = make_row(0, 0, CMD_SORT,    0,  0,  0, 0, 0, 0, 0, 0);
        dir_plan[17] = make_row(0, 0, CMD_SEARCH,  0,  32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
        dir_plan[18] = make_row(0, 0, CMD_READ,    3,  0,  0, 0, 0, 0, 0, 0);
        dir_plan[19] = make_row(0, 0, CMD_DELETE,  0,  0,  1, STAT_OK,  0, 0, 0, 3);
        dir_plan[20] = make_row(0, 0, CMD_DELETE,  3,  0,  1, STAT_OOR, 0, 0, 0, 3);
        dir_plan[21] = make_row(1, 2, CMD_APPEND,  0,  1,  1, STAT_FULL, 0, 0, 0, 3);
        dir_plan[22] = make_row(0, 0, CMD_INSERT,  5,  1,  1, STAT_OOR, 0, 0, 0, 3);
        dir_plan[23] = make_row(0, 0, CMD_INSERT,  0,  1,  1, STAT_FULL, 0, 0, 0, 3);
        dir_plan[24] = make_row(1, 63, CMD_APPEND, 0,  2,  0, 0, 0, 0, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < N_DIRECTED; k++)
        begin
            if (dir_plan[k].cfg_wr)
                write_capacity(dir_plan[k].cfg_cap);
            issue_cmd(dir_plan[k].beat, dir_plan[k].known, dir_plan[k].want);
        end

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph % 7)
                0: write_capacity(DEPTH_CNT);
                1: write_capacity(6'd0);
                2: write_capacity(CNT_W'($urandom_range(1, 31)));
                3: write_capacity(6'd63);
                4: write_capacity(6'd1);
                5: write_capacity(CNT_W'($urandom_range(33, 63)));
                default: write_capacity(CNT_W'($urandom_range(0, 32)));
            endcase
            // no idling in the last phase; some phases run without it too
            idle_on = (ph != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
            grow = (ph % 7 == 0) ? 75 : $urandom_range(5, 80);
            for (k = 0; k < PHASE_LEN; k++)
            begin
                if ($urandom_range(0, 99) < grow)
                    op = ($urandom_range(0, 1) != 0) ? CMD_APPEND : CMD_INSERT;
                else
                begin
                    pick = $urandom_range(0, 19);
                    if (pick < 6)
                        op = CMD_DELETE;
                    else if (pick < 10)
                        op = CMD_READ;
                    else if (pick < 13)
                        op = CMD_FIND;
                    else if (pick < 15)
                        op = CMD_SORT;
                    else if (pick < 18)
                        op = CMD_SEARCH;
                    else if (pick == 18)
                        op = CMD_UNKNOWN;
                    else
                        op = 3'($urandom);
                end
                beat.cmd = op;
                if ($urandom_range(0, 4) != 0)
                    beat.position = CNT_W'($urandom_range(0, list_len));
                else
                    beat.position = CNT_W'($urandom_range(0, 63));
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    beat.value = VALUE_W'($urandom_range(0, 6)) - 3;
                else if (pick < 7 && list_len > 0)
                    beat.value = list_mem[$urandom_range(0, list_len - 1)];
                else
                    beat.value = $urandom;
                issue_cmd(beat, 1'b0, none);
            end
        end

        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/blte_pkg.sv
design/blte_cell.sv
design/bounded_list_table_engine_unit.sv
bench/tb_bounded_list_table_engine_unit.sv
